// ===== design/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg: shared definitions for the divisor count and sum block
// Widths, field sizes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    // Width of the number that is factored (8 to 32).
    localparam int N_WIDTH     = 32;
    localparam int IN_WIDTH    = 32;
    // A trial divisor never exceeds the square root of the number plus one.
    localparam int D_WIDTH     = N_WIDTH / 2 + 1;
    localparam int SQ_WIDTH    = 2 * D_WIDTH;
    localparam int EXP_WIDTH   = 6;
    localparam int CNT_WIDTH   = 11;
    localparam int SUM_WIDTH   = 35;
    // Split of the series sum for the two partial products of the fold.
    localparam int SUM_LO_W    = SUM_WIDTH / 2 + 1;
    localparam int SUM_HI_W    = SUM_WIDTH - SUM_LO_W;
    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS   = (N_WIDTH + 1) / 2;
    localparam int DIV_W       = 2 * DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;        // take a new number and set the products to one
        logic div_start;   // divide the remainder by the trial divisor
        logic hit;         // divisor divides: keep quotient, raise power
        logic accum;       // add the new prime power to the series
        logic fold_lo;     // first partial product of the sum fold
        logic fold_hi;     // second partial product and count fold
        logic fold_sum;    // combine partial products into the sum
        logic advance;     // move on to the next trial divisor
        logic tail;        // leftover prime with exponent one
        logic out_load;    // capture the result
    } dcs_cmd_t;

    typedef struct packed {
        logic square_gt;   // trial divisor squared exceeds remainder
        logic div_done;
        logic div_rem_zero;
        logic exp_nonzero;
        logic rem_gt_one;
    } dcs_status_t;

endpackage

`default_nettype wire

// ===== design/dcs_if.sv =====
// ----------------------------------------------------------------------------
// dcs_if: channel interfaces of the divisor count and sum block
// A request channel carrying the number and a result channel carrying the
// divisor count and sum, both with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_req_if;
    import dcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [IN_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface dcs_res_if;
    import dcs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CNT_WIDTH-1:0] divisor_count;
    logic [SUM_WIDTH-1:0] divisor_sum;

    modport source (output valid, output divisor_count, output divisor_sum, input ready);
    modport sink   (input valid, input divisor_count, input divisor_sum, output ready);
endinterface

`default_nettype wire

// ===== design/dcs_divider.sv =====
// ----------------------------------------------------------------------------
// dcs_divider: radix-4 restoring divider
// Divides the remainder by the trial divisor, two quotient bits per cycle,
// and reports the quotient and whether the division left nothing over.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dcs_pkg::DIV_W-1:0]   dividend,
    input  wire logic [dcs_pkg::D_WIDTH-1:0] divisor,
    output logic                             done,
    output logic [dcs_pkg::DIV_W-1:0]        quotient,
    output logic                             rem_zero
);
    import dcs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [D_WIDTH-1:0]   r_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [D_WIDTH-1:0]   d_reg;

    logic [D_WIDTH:0]     step1;
    logic [D_WIDTH:0]     step2;
    logic [D_WIDTH-1:0]   r_next;
    logic [DIV_W-1:0]     q_next;

    // One restoring step: returns the quotient bit above the new remainder.
    function automatic logic [D_WIDTH:0] div_step(input logic [D_WIDTH-1:0] r,
                                                  input logic             b,
                                                  input logic [D_WIDTH-1:0] d);
        logic [D_WIDTH:0] t;
        logic [D_WIDTH:0] dd;
        t  = {r, b};
        dd = {1'b0, d};
        if (t >= dd)
        begin
            div_step = {1'b1, D_WIDTH'(t - dd)};
        end
        else
        begin
            div_step = {1'b0, t[D_WIDTH-1:0]};
        end
    endfunction

    always_comb
    begin
        step1  = div_step(r_reg, q_reg[DIV_W-1], d_reg);
        step2  = div_step(step1[D_WIDTH-1:0], q_reg[DIV_W-2], d_reg);
        r_next = step2[D_WIDTH-1:0];
        q_next = {q_reg[DIV_W-3:0], step1[D_WIDTH], step2[D_WIDTH]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign rem_zero = (r_reg == '0);

endmodule

`default_nettype wire

// ===== design/dcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dcs_datapath: factoring datapath
// Holds the remainder, trial divisor and its square, the running prime
// power and series, the two products and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dcs_pkg::dcs_cmd_t             cmd,
    input  wire logic [dcs_pkg::IN_WIDTH-1:0]  number,
    output dcs_pkg::dcs_status_t               status,
    output logic [dcs_pkg::CNT_WIDTH-1:0]      divisor_count,
    output logic [dcs_pkg::SUM_WIDTH-1:0]      divisor_sum
);
    import dcs_pkg::*;

    logic [N_WIDTH-1:0]   rem_reg,    rem_next;
    logic [D_WIDTH-1:0]   d_reg,      d_next;
    logic [SQ_WIDTH-1:0]  sq_reg,     sq_next;
    logic [EXP_WIDTH-1:0] exp_reg,    exp_next;
    logic [CNT_WIDTH-1:0] cp_reg,     cp_next;
    logic [SUM_WIDTH-1:0] sp_reg,     sp_next;
    logic [SUM_WIDTH-1:0] pp_reg,     pp_next;
    logic [SUM_WIDTH-1:0] ser_reg,    ser_next;
    logic [SUM_WIDTH-1:0] lo_reg,     lo_next;
    logic [SUM_WIDTH-1:0] hi_reg,     hi_next;
    logic [CNT_WIDTH-1:0] cnt_out_reg;
    logic [SUM_WIDTH-1:0] sum_out_reg;

    logic                 div_done;
    logic                 div_rem_zero;
    logic [DIV_W-1:0]     div_quot;

    dcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (DIV_W'(rem_reg)),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quot),
        .rem_zero (div_rem_zero)
    );

    always_comb
    begin
        rem_next = rem_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        exp_next = exp_reg;
        cp_next  = cp_reg;
        sp_next  = sp_reg;
        pp_next  = pp_reg;
        ser_next = ser_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;

        if (cmd.load)
        begin
            rem_next = number[N_WIDTH-1:0];
            d_next   = D_WIDTH'(2);
            sq_next  = SQ_WIDTH'(4);
            exp_next = '0;
            cp_next  = CNT_WIDTH'(1);
            sp_next  = SUM_WIDTH'(1);
            pp_next  = SUM_WIDTH'(1);
            ser_next = SUM_WIDTH'(1);
        end
        if (cmd.hit)
        begin
            rem_next = div_quot[N_WIDTH-1:0];
            pp_next  = SUM_WIDTH'(pp_reg * SUM_WIDTH'(d_reg));
            exp_next = exp_reg + EXP_WIDTH'(1);
        end
        if (cmd.accum)
        begin
            ser_next = ser_reg + pp_reg;
        end
        if (cmd.fold_lo)
        begin
            lo_next = SUM_WIDTH'(sp_reg * SUM_WIDTH'(ser_reg[SUM_LO_W-1:0]));
        end
        if (cmd.fold_hi)
        begin
            hi_next = SUM_WIDTH'(sp_reg * SUM_WIDTH'(ser_reg[SUM_WIDTH-1:SUM_LO_W]));
            cp_next = CNT_WIDTH'(cp_reg * (CNT_WIDTH'(exp_reg) + CNT_WIDTH'(1)));
        end
        if (cmd.fold_sum)
        begin
            // Only the low bits of the full product are kept.
            sp_next = lo_reg + (hi_reg << SUM_LO_W);
        end
        if (cmd.advance)
        begin
            d_next   = d_reg + D_WIDTH'(1);
            sq_next  = sq_reg + SQ_WIDTH'({d_reg, 1'b0}) + SQ_WIDTH'(1);
            exp_next = '0;
            pp_next  = SUM_WIDTH'(1);
            ser_next = SUM_WIDTH'(1);
        end
        if (cmd.tail)
        begin
            exp_next = EXP_WIDTH'(1);
            ser_next = SUM_WIDTH'(rem_reg) + SUM_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        cp_reg  <= cp_next;
        sp_reg  <= sp_next;
        pp_reg  <= pp_next;
        ser_reg <= ser_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (cmd.out_load)
        begin
            cnt_out_reg <= cp_reg;
            sum_out_reg <= sp_reg;
        end
    end

    always_comb
    begin
        status.square_gt    = (sq_reg > SQ_WIDTH'(rem_reg));
        status.div_done     = div_done;
        status.div_rem_zero = div_rem_zero;
        status.exp_nonzero  = (exp_reg != '0);
        status.rem_gt_one   = (rem_reg > N_WIDTH'(1));
    end

    assign divisor_count = cnt_out_reg;
    assign divisor_sum   = sum_out_reg;

endmodule

`default_nettype wire

// ===== design/dcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcs_ctrl: factoring controller
// Sequences the trial divisions, the folds of each prime into the products
// and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    input  wire dcs_pkg::dcs_status_t status,
    output dcs_pkg::dcs_cmd_t         cmd
);
    import dcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ACCUM,
        S_FOLD_LO,
        S_FOLD_HI,
        S_FOLD_SUM,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   tail_reg,  tail_next;
    logic   valid_reg, valid_next;
    logic   res_transfer;

    assign res_transfer = valid_reg && res_ready;

    always_comb
    begin
        state_next = state_reg;
        tail_next  = tail_reg;
        valid_next = res_transfer ? 1'b0 : valid_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    tail_next  = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.square_gt)
                begin
                    if (status.rem_gt_one)
                    begin
                        cmd.tail   = 1'b1;
                        tail_next  = 1'b1;
                        state_next = S_FOLD_LO;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    if (status.div_rem_zero)
                    begin
                        cmd.hit    = 1'b1;
                        state_next = S_ACCUM;
                    end
                    else if (status.exp_nonzero)
                    begin
                        state_next = S_FOLD_LO;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_ACCUM:
            begin
                // The same divisor is tried again on the new quotient.
                cmd.accum     = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_FOLD_LO:
            begin
                cmd.fold_lo = 1'b1;
                state_next  = S_FOLD_HI;
            end
            S_FOLD_HI:
            begin
                cmd.fold_hi = 1'b1;
                state_next  = S_FOLD_SUM;
            end
            S_FOLD_SUM:
            begin
                cmd.fold_sum = 1'b1;
                if (tail_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE:
            begin
                // Wait until the output register is free before loading it.
                if (!valid_reg || res_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            valid_reg <= valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/divisor_count_and_sum_top.sv =====
// ----------------------------------------------------------------------------
// divisor_count_and_sum_top: divisor count and divisor sum by trial division
// Factors one number at a time and returns tau and sigma of it.
// ----------------------------------------------------------------------------
// The block takes one number on the request channel, factors it by trial
// division and returns the number of divisors and the sum of divisors on the
// result channel; inputs of zero and one both give a count and sum of one.
// One number is worked on at a time, while the previous result may still wait
// in the output register. Each trial divisor gets a square test and, if
// its square does not exceed the remainder, a division in the radix-4
// divider. A divisor that divides is tried again on the quotient, and each
// distinct prime, a leftover one included, is then folded into the count and
// the sum in a low, a high and a sum fold step. The result is loaded only
// once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_count_and_sum_top (
    input  wire logic clk,
    input  wire logic rst_n,
    dcs_req_if.sink   request,
    dcs_res_if.source result
);
    import dcs_pkg::*;

    dcs_cmd_t    cmd;
    dcs_status_t status;

    dcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dcs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .number        (request.number),
        .status        (status),
        .divisor_count (result.divisor_count),
        .divisor_sum   (result.divisor_sum)
    );

endmodule

`default_nettype wire

// ===== design/dcs_checker.sv =====
// ----------------------------------------------------------------------------
// dcs_checker: port checks for the divisor count and sum block
// Watches both channels of the top level and flags results and handshakes
// that the block can never produce.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           res_valid,
    input wire logic                           res_ready,
    input wire logic [dcs_pkg::CNT_WIDTH-1:0]  divisor_count,
    input wire logic [dcs_pkg::SUM_WIDTH-1:0]  divisor_sum
);
    import dcs_pkg::*;

    // A result stays offered until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(divisor_count) && $stable(divisor_sum))
        else $error("result payload changed while stalled");

    // Every result counts at least the divisor one.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> divisor_count != '0 && divisor_sum != '0)
        else $error("zero divisor count or sum");

    // Each divisor is at least one, so the sum never falls below the count.
    a_sum_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> divisor_sum >= SUM_WIDTH'(divisor_count))
        else $error("divisor sum below divisor count");

    // Only one number is factored at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while factoring");

endmodule

bind divisor_count_and_sum_top dcs_checker u_dcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .divisor_count (result.divisor_count),
    .divisor_sum   (result.divisor_sum)
);

`default_nettype wire
